FILE: rtl/core/rgblab_pkg.sv
// Shared types, constants and table functions of the RGB to CIELAB converter.
// The gamma and cube-root functions are evaluated only at elaboration to fill constant tables.
// No dependencies.
package rgblab_pkg;

	localparam int FRAC_BITS       = 8;
	localparam int CBRT_TABLE_BITS = 10;

	localparam int Q_BITS   = 20;
	localparam int LIN_W    = 17;
	localparam int COEF_W   = 20;
	localparam int PROD_W   = 37;
	localparam int NUM_W    = 41;
	localparam int NT_LSB   = 12;
	localparam int RECIP_K  = 44;
	localparam int RECIP_W  = 25;
	localparam int QP_W     = 54;
	localparam int Q_LSB    = RECIP_K - NT_LSB;
	localparam int XYZ_W    = 21;
	localparam int DIV_W    = 21;
	localparam int DP_W     = 42;

	localparam int CBRT_SHIFT   = Q_BITS - CBRT_TABLE_BITS;
	localparam int CBRT_ENTRIES = (1 << CBRT_TABLE_BITS) + 1;
	localparam int CBRT_AW      = CBRT_TABLE_BITS + 1;

	localparam logic [XYZ_W-1:0] F_THRESH = XYZ_W'(9286);
	localparam logic [XYZ_W-1:0] F_OFFSET = XYZ_W'(144631);
	localparam logic [XYZ_W-1:0] F_ONE    = XYZ_W'(1 << Q_BITS);

	localparam int RND_SHIFT = Q_BITS - FRAC_BITS;
	localparam int L_LIMIT   = ((100 << FRAC_BITS) > 32767) ? 32767 : (100 << FRAC_BITS);
	localparam logic [14:0] L_MAX = 15'(L_LIMIT);

	localparam logic [63:0] D_X = 64'd950456;
	localparam logic [63:0] D_Y = 64'd1000000;
	localparam logic [63:0] D_Z = 64'd1088754;

	localparam logic [COEF_W-1:0] MAT [3][3] = '{
		'{20'd412453, 20'd357580, 20'd180423},
		'{20'd212671, 20'd715160, 20'd72169},
		'{20'd19334,  20'd119193, 20'd950227}
	};

	localparam logic [DIV_W-1:0] DIV_D [3] = '{
		DIV_W'(D_X), DIV_W'(D_Y), DIV_W'(D_Z)
	};

	localparam logic [DIV_W-1:0] DIV_HALF [3] = '{
		DIV_W'(D_X >> 1), DIV_W'(D_Y >> 1), DIV_W'(D_Z >> 1)
	};

	localparam logic [RECIP_W-1:0] RECIP [3] = '{
		RECIP_W'((64'd1 << RECIP_K) / D_X),
		RECIP_W'((64'd1 << RECIP_K) / D_Y),
		RECIP_W'((64'd1 << RECIP_K) / D_Z)
	};

	localparam int DIV1000_K = 37;
	localparam logic [27:0] DIV1000_M = 28'(((64'd1 << DIV1000_K) + 64'd999) / 64'd1000);
	localparam int DIV10_K = 31;
	localparam logic [27:0] DIV10_M = 28'(((64'd1 << DIV10_K) + 64'd9) / 64'd10);

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} pixel_t;

	typedef struct packed {
		logic        [14:0] lightness;
		logic signed [15:0] green_red;
		logic signed [15:0] blue_yellow;
	} lab_t;

	typedef struct packed {
		logic rd;
		logic mul;
		logic sel;
	} cief_en_t;

	function automatic logic [LIN_W-1:0] gamma_entry(input logic [7:0] c);
		logic [63:0] cc;
		logic [63:0] u;
		logic [63:0] u2;
		logic [63:0] lo;
		logic [63:0] hi;
		logic [63:0] mid;
		logic [63:0] w2;
		logic [63:0] w4;
		logic [63:0] p5;
		logic [63:0] lin;
		int k;
		cc = 64'(c);
		if (cc <= 64'd10) begin
			return LIN_W'((cc * 64'd6553600 + 64'd164730) / 64'd329460);
		end
		u  = ((64'd1000 * cc + 64'd14025) * 64'd16777216 + 64'd134512) / 64'd269025;
		u2 = (u * u) >> 24;
		lo = 64'd0;
		hi = 64'd16777216;
		for (k = 0; k < 26; k++) begin
			if (lo < hi) begin
				mid = (lo + hi + 64'd1) >> 1;
				w2  = (mid * mid) >> 24;
				w4  = (w2 * w2) >> 24;
				p5  = (w4 * mid) >> 24;
				if (p5 <= u2) begin
					lo = mid;
				end else begin
					hi = mid - 64'd1;
				end
			end
		end
		lin = (u2 * lo) >> 24;
		return LIN_W'((lin + 64'd128) >> 8);
	endfunction

	function automatic logic [XYZ_W-1:0] cbrt_entry(input logic [CBRT_AW-1:0] i);
		logic [63:0] target;
		logic [63:0] lo;
		logic [63:0] hi;
		logic [63:0] mid;
		int k;
		target = 64'(i) << (60 - CBRT_TABLE_BITS);
		lo = 64'd0;
		hi = (64'd1 << 21) - 64'd1;
		for (k = 0; k < 23; k++) begin
			if (lo < hi) begin
				mid = (lo + hi + 64'd1) >> 1;
				if (mid * mid * mid <= target) begin
					lo = mid;
				end else begin
					hi = mid - 64'd1;
				end
			end
		end
		return XYZ_W'(lo);
	endfunction

endpackage

FILE: rtl/core/rgblab_cie_f.sv
// CIE f function on one Q20 tristimulus value, three pipeline stages.
// Holds the cube-root ROM; takes stage enables from the top level.
// Depends on rgblab_pkg.
module rgblab_cie_f (
	input  logic                                 clk,
	input  rgblab_pkg::cief_en_t                 en,
	input  logic [rgblab_pkg::XYZ_W-1:0]         t,
	output logic [rgblab_pkg::XYZ_W-1:0]         f
);

	localparam int CB   = rgblab_pkg::CBRT_TABLE_BITS;
	localparam int SH   = rgblab_pkg::CBRT_SHIFT;
	localparam int AW   = rgblab_pkg::CBRT_AW;
	localparam int EW   = rgblab_pkg::XYZ_W;
	localparam int DPW  = EW + SH;
	localparam logic [DPW:0] HALF = (DPW + 1)'(1) << (SH - 1);

	logic [EW-1:0] cbrt_rom [rgblab_pkg::CBRT_ENTRIES];

	for (genvar i = 0; i < rgblab_pkg::CBRT_ENTRIES; i++) begin : g_rom
		localparam logic [EW-1:0] ENTRY = rgblab_pkg::cbrt_entry(AW'(i));
		assign cbrt_rom[i] = ENTRY;
	end

	logic [AW-1:0] addr0;
	logic [AW-1:0] addr1;
	logic          top;

	assign addr0 = t[EW-1:SH];
	assign top   = addr0[CB];
	assign addr1 = top ? addr0 : addr0 + AW'(1);

	logic [EW-1:0] e0_s7;
	logic [EW-1:0] e1_s7;
	logic [SH-1:0] frac_s7;
	logic          top_s7;
	logic          small_s7;
	logic [26:0]   lmul_s7;

	always_ff @(posedge clk) begin
		if (en.rd) begin
			e0_s7    <= cbrt_rom[addr0];
			e1_s7    <= cbrt_rom[addr1];
			frac_s7  <= t[SH-1:0];
			top_s7   <= top;
			small_s7 <= (t <= rgblab_pkg::F_THRESH);
			lmul_s7  <= 27'(t[13:0]) * 27'd7787;
		end
	end

	logic [EW-1:0]  e0_s8;
	logic [DPW-1:0] dprod_s8;
	logic [54:0]    lprod_s8;
	logic           top_s8;
	logic           small_s8;

	always_ff @(posedge clk) begin
		if (en.mul) begin
			e0_s8    <= e0_s7;
			dprod_s8 <= DPW'(e1_s7 - e0_s7) * DPW'(frac_s7);
			lprod_s8 <= 55'(lmul_s7 + 27'd500) * 55'(rgblab_pkg::DIV1000_M);
			top_s8   <= top_s7;
			small_s8 <= small_s7;
		end
	end

	logic [EW-1:0] interp;
	logic [EW-1:0] linear;
	logic [EW-1:0] f_s9;

	assign interp = e0_s8 + EW'(((DPW + 1)'(dprod_s8) + HALF) >> SH);
	assign linear = EW'(lprod_s8 >> rgblab_pkg::DIV1000_K) + rgblab_pkg::F_OFFSET;

	always_ff @(posedge clk) begin
		if (en.sel) begin
			if (top_s8) begin
				f_s9 <= rgblab_pkg::F_ONE;
			end else if (small_s8) begin
				f_s9 <= linear;
			end else begin
				f_s9 <= interp;
			end
		end
	end

	assign f = f_s9;

endmodule

FILE: rtl/core/rgb_to_cielab_converter.sv
// Top level of the RGB to CIELAB converter: gamma table, XYZ matrix and division, Lab output.
// Instantiates rgblab_cie_f three times; depends on rgblab_pkg.
//
// channel  | dir | handshake                    | payload
// pixel    | in  | pixel_valid / pixel_stall    | rgblab_pkg::pixel_t (red, green, blue)
// lab      | out | lab_valid / lab_stall        | rgblab_pkg::lab_t (lightness, green_red,
//          |     |                              |   blue_yellow)
//
// The pipeline has 11 stages, and one request enters per cycle while pixel_stall is low.
// The stages are gamma lookup, matrix multiply, sum, reciprocal multiply, multiply back by the divisor, correction,
// cube-root ROM read, interpolation multiply, f select, Lab scaling and output rounding.
// A stage holds only while it is full and the stage after it holds, so bubbles close up
// under a stall on the lab side. Reset clears only the stage valid bits.
module rgb_to_cielab_converter (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                pixel_valid,
	output logic                pixel_stall,
	input  rgblab_pkg::pixel_t  pixel,
	output logic                lab_valid,
	input  logic                lab_stall,
	output rgblab_pkg::lab_t    lab
);

	localparam int NST   = 11;
	localparam int LIN_W = rgblab_pkg::LIN_W;
	localparam int XW    = rgblab_pkg::XYZ_W;
	localparam int RSH   = rgblab_pkg::RND_SHIFT;

	logic [NST:1] stage_vld_q;
	logic [NST:1] en;

	always_comb begin
		en[NST] = !stage_vld_q[NST] || !lab_stall;
		for (int k = NST - 1; k >= 1; k--) begin
			en[k] = !stage_vld_q[k] || en[k+1];
		end
	end

	assign pixel_stall = !en[1];
	assign lab_valid   = stage_vld_q[NST];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stage_vld_q <= '0;
		end else begin
			if (en[1]) begin
				stage_vld_q[1] <= pixel_valid;
			end
			for (int k = 2; k <= NST; k++) begin
				if (en[k]) begin
					stage_vld_q[k] <= stage_vld_q[k-1];
				end
			end
		end
	end

	logic [LIN_W-1:0] gamma_lut [256];

	for (genvar g = 0; g < 256; g++) begin : g_gamma
		localparam logic [LIN_W-1:0] ENTRY = rgblab_pkg::gamma_entry(8'(g));
		assign gamma_lut[g] = ENTRY;
	end

	logic [LIN_W-1:0] lin_s1 [3];

	always_ff @(posedge clk) begin
		if (en[1]) begin
			lin_s1[0] <= gamma_lut[pixel.red];
			lin_s1[1] <= gamma_lut[pixel.green];
			lin_s1[2] <= gamma_lut[pixel.blue];
		end
	end

	logic [rgblab_pkg::PROD_W-1:0] prod_s2 [3][3];

	always_ff @(posedge clk) begin
		if (en[2]) begin
			for (int r = 0; r < 3; r++) begin
				for (int c = 0; c < 3; c++) begin
					prod_s2[r][c] <= rgblab_pkg::PROD_W'(lin_s1[c]) *
						rgblab_pkg::PROD_W'(rgblab_pkg::MAT[r][c]);
				end
			end
		end
	end

	logic [rgblab_pkg::NUM_W-1:0] num_s3 [3];

	always_ff @(posedge clk) begin
		if (en[3]) begin
			for (int r = 0; r < 3; r++) begin
				num_s3[r] <= {prod_s2[r][0] + prod_s2[r][1] + prod_s2[r][2], 4'b0000} +
					rgblab_pkg::NUM_W'(rgblab_pkg::DIV_HALF[r]);
			end
		end
	end

	logic [rgblab_pkg::QP_W-1:0]  qp_s4  [3];
	logic [rgblab_pkg::NUM_W-1:0] num_s4 [3];

	always_ff @(posedge clk) begin
		if (en[4]) begin
			for (int r = 0; r < 3; r++) begin
				qp_s4[r]  <= rgblab_pkg::QP_W'(num_s3[r][rgblab_pkg::NUM_W-1:rgblab_pkg::NT_LSB]) *
					rgblab_pkg::QP_W'(rgblab_pkg::RECIP[r]);
				num_s4[r] <= num_s3[r];
			end
		end
	end

	logic [XW-1:0]                qe_s5  [3];
	logic [rgblab_pkg::DP_W-1:0]  dp_s5  [3];
	logic [rgblab_pkg::NUM_W-1:0] num_s5 [3];

	always_ff @(posedge clk) begin
		if (en[5]) begin
			for (int r = 0; r < 3; r++) begin
				qe_s5[r]  <= qp_s4[r][rgblab_pkg::Q_LSB+XW-1:rgblab_pkg::Q_LSB];
				dp_s5[r]  <= rgblab_pkg::DP_W'(qp_s4[r][rgblab_pkg::Q_LSB+XW-1:rgblab_pkg::Q_LSB]) *
					rgblab_pkg::DP_W'(rgblab_pkg::DIV_D[r]);
				num_s5[r] <= num_s4[r];
			end
		end
	end

	logic [rgblab_pkg::DP_W-1:0] rem [3];
	logic [XW-1:0]               xyz_s6 [3];

	always_comb begin
		for (int r = 0; r < 3; r++) begin
			rem[r] = rgblab_pkg::DP_W'(num_s5[r]) - dp_s5[r];
		end
	end

	always_ff @(posedge clk) begin
		if (en[6]) begin
			for (int r = 0; r < 3; r++) begin
				xyz_s6[r] <= qe_s5[r] +
					XW'(rem[r] >= rgblab_pkg::DP_W'(rgblab_pkg::DIV_D[r]));
			end
		end
	end

	rgblab_pkg::cief_en_t f_en;
	logic [XW-1:0]        f_xyz [3];

	assign f_en = '{rd: en[7], mul: en[8], sel: en[9]};

	for (genvar r = 0; r < 3; r++) begin : g_f
		rgblab_cie_f u_f (
			.clk (clk),
			.en  (f_en),
			.t   (xyz_s6[r]),
			.f   (f_xyz[r])
		);
	end

	logic        ysmall_s7;
	logic [27:0] lym_s7;
	logic        ysmall_s8;
	logic [55:0] lyp_s8;
	logic        ysmall_s9;
	logic [24:0] ly_s9;

	always_ff @(posedge clk) begin
		if (en[7]) begin
			ysmall_s7 <= (xyz_s6[1] <= rgblab_pkg::F_THRESH);
			lym_s7    <= 28'(xyz_s6[1][13:0]) * 28'd9033;
		end
		if (en[8]) begin
			ysmall_s8 <= ysmall_s7;
			lyp_s8    <= 56'(lym_s7 + 28'd5) * 56'(rgblab_pkg::DIV10_M);
		end
		if (en[9]) begin
			ysmall_s9 <= ysmall_s8;
			ly_s9     <= lyp_s8[rgblab_pkg::DIV10_K+24:rgblab_pkg::DIV10_K];
		end
	end

	logic signed [21:0] d_xy;
	logic signed [21:0] d_yz;
	logic signed [29:0] l_big;
	logic signed [29:0] l_s10;
	logic signed [30:0] a_s10;
	logic signed [30:0] b_s10;

	assign d_xy  = $signed({1'b0, f_xyz[0]}) - $signed({1'b0, f_xyz[1]});
	assign d_yz  = $signed({1'b0, f_xyz[1]}) - $signed({1'b0, f_xyz[2]});
	assign l_big = $signed(30'(f_xyz[1])) * 30'sd116 - (30'sd16 <<< rgblab_pkg::Q_BITS);

	always_ff @(posedge clk) begin
		if (en[10]) begin
			l_s10 <= ysmall_s9 ? $signed(30'(ly_s9)) : l_big;
			a_s10 <= 31'(d_xy) * 31'sd500;
			b_s10 <= 31'(d_yz) * 31'sd200;
		end
	end

	logic signed [29:0] l_rnd;
	logic signed [30:0] a_rnd;
	logic signed [30:0] b_rnd;
	rgblab_pkg::lab_t   lab_next;
	rgblab_pkg::lab_t   lab_s11;

	assign l_rnd = (l_s10 + (30'sd1 <<< (RSH - 1))) >>> RSH;
	assign a_rnd = (a_s10 + (31'sd1 <<< (RSH - 1))) >>> RSH;
	assign b_rnd = (b_s10 + (31'sd1 <<< (RSH - 1))) >>> RSH;

	always_comb begin
		if (l_rnd[29]) begin
			lab_next.lightness = '0;
		end else if (l_rnd > $signed(30'(rgblab_pkg::L_MAX))) begin
			lab_next.lightness = rgblab_pkg::L_MAX;
		end else begin
			lab_next.lightness = l_rnd[14:0];
		end
		if (a_rnd > 31'sd32767) begin
			lab_next.green_red = 16'sh7fff;
		end else if (a_rnd < -31'sd32768) begin
			lab_next.green_red = 16'sh8000;
		end else begin
			lab_next.green_red = a_rnd[15:0];
		end
		if (b_rnd > 31'sd32767) begin
			lab_next.blue_yellow = 16'sh7fff;
		end else if (b_rnd < -31'sd32768) begin
			lab_next.blue_yellow = 16'sh8000;
		end else begin
			lab_next.blue_yellow = b_rnd[15:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en[NST]) begin
			lab_s11 <= lab_next;
		end
	end

	assign lab = lab_s11;

endmodule
